// ===== rtl/core/half_duplex_bitbang_uart_assert.svh =====
// Assertion macros for the half-duplex serial engine.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef HALF_DUPLEX_BITBANG_UART_ASSERT_SVH
`define HALF_DUPLEX_BITBANG_UART_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HDBU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HDBU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/hdbu_pkg.sv =====
// Shared types and constants of the half-duplex serial engine.
// No dependencies; front, back, top and testbench use it by scoped names.
package hdbu_pkg;

  // Receive FIFO geometry. One slot always stays free.
  localparam int FIFO_DEPTH = 32;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = PTR_W + 1;
  localparam int FILL_W     = 5;

  // Command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QSEL_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QSEL_W + 1;

  // Request codes as seen on the input channel.
  localparam logic [2:0] REQ_TICK   = 3'd0;
  localparam logic [2:0] REQ_LOAD   = 3'd1;
  localparam logic [2:0] REQ_POP    = 3'd2;
  localparam logic [2:0] REQ_RX_ON  = 3'd3;
  localparam logic [2:0] REQ_RX_OFF = 3'd4;

  // Bit-period phases of the transmitter and receiver.
  localparam logic [3:0] PH_START     = 4'd0;
  localparam logic [3:0] PH_FIRST     = 4'd1;
  localparam logic [3:0] PH_LAST_DATA = 4'd8;
  localparam logic [3:0] PH_STOP      = 4'd9;
  localparam logic [3:0] PH_EXTRA     = 4'd10;

  // Classified operation carried through the queue.
  typedef enum logic [2:0] {
    OP_NOP    = 3'd0,
    OP_TICK   = 3'd1,
    OP_LOAD   = 3'd2,
    OP_POP    = 3'd3,
    OP_RX_ON  = 3'd4,
    OP_RX_OFF = 3'd5
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       line_in;
    logic [7:0] tx_byte;
    logic       tx_last;
  } cmd_t;

  // Result fields other than the popped byte.
  typedef struct packed {
    logic              line_out;
    logic              drive_enable;
    logic              tx_active;
    logic              rx_data_valid;
    logic [FILL_W-1:0] rx_fill;
    logic              rx_overflow;
  } status_t;

endpackage

// ===== rtl/core/hdbu_if.sv =====
// Handshake channels of the half-duplex serial engine: requests in, results out.
// Depends on nothing but plain logic types.
interface hdbu_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic       line_in;
  logic [7:0] tx_byte;
  logic       tx_last;

  modport source (output valid, req_type, line_in, tx_byte, tx_last, input ready);
  modport sink   (input valid, req_type, line_in, tx_byte, tx_last, output ready);
endinterface

interface hdbu_out_if;
  logic       valid;
  logic       ready;
  logic       line_out;
  logic       drive_enable;
  logic       tx_active;
  logic [7:0] rx_data;
  logic       rx_data_valid;
  logic [4:0] rx_fill;
  logic       rx_overflow;

  modport source (output valid, line_out, drive_enable, tx_active, rx_data, rx_data_valid,
                  rx_fill, rx_overflow, input ready);
  modport sink   (input valid, line_out, drive_enable, tx_active, rx_data, rx_data_valid,
                  rx_fill, rx_overflow, output ready);
endinterface

// ===== rtl/core/half_duplex_bitbang_uart.sv =====
// Top level of the half-duplex serial engine: joins hdbu_front and hdbu_back, uses hdbu_pkg.
// An accepted request waits in the command queue until the result register is free, is then
// executed into it and offered from there. Throughput: one request per cycle while results
// are taken; a two-entry command queue lets the front keep accepting two more requests while
// the result register waits on a stalled consumer.
// Reset: synchronous, active low; wire idles high and driven, receiver off, FIFO empty.
module half_duplex_bitbang_uart (
  input logic       clk,
  input logic       rst_n,
  hdbu_in_if.sink   in_ch,
  hdbu_out_if.source out_ch
);

  logic              cmd_valid;
  hdbu_pkg::cmd_t    cmd;
  logic              cmd_take;
  hdbu_pkg::status_t res_status;

  // Request intake and classification.
  hdbu_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_req_type (in_ch.req_type),
    .in_line_in  (in_ch.line_in),
    .in_tx_byte  (in_ch.tx_byte),
    .in_tx_last  (in_ch.tx_last),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_take    (cmd_take)
  );

  // Serial engine and result register; a FIFO byte is only delivered after being written.
  hdbu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take),
    .res_valid  (out_ch.valid),
    .res_ready  (out_ch.ready),
    .res_status (res_status),
    .res_data   (out_ch.rx_data)
  );

  assign out_ch.line_out      = res_status.line_out;
  assign out_ch.drive_enable  = res_status.drive_enable;
  assign out_ch.tx_active     = res_status.tx_active;
  assign out_ch.rx_data_valid = res_status.rx_data_valid;
  assign out_ch.rx_fill       = res_status.rx_fill;
  assign out_ch.rx_overflow   = res_status.rx_overflow;

endmodule

// ===== rtl/core/hdbu_front.sv =====
// Front end: accepts requests, classifies them and holds them in a short queue.
// Depends on hdbu_pkg.
module hdbu_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       in_req_type,
  input  logic             in_line_in,
  input  logic [7:0]       in_tx_byte,
  input  logic             in_tx_last,
  output logic             cmd_valid,
  output hdbu_pkg::cmd_t   cmd,
  input  logic             cmd_take
);

  hdbu_pkg::cmd_t                  queue_r [hdbu_pkg::QUEUE_DEPTH];
  logic [hdbu_pkg::QSEL_W-1:0]     wr_sel_r, wr_sel_nxt;
  logic [hdbu_pkg::QSEL_W-1:0]     rd_sel_r, rd_sel_nxt;
  logic [hdbu_pkg::QCNT_W-1:0]     count_r, count_nxt;
  logic                            push, pop;
  hdbu_pkg::op_t                   op;
  hdbu_pkg::cmd_t                  new_cmd;

  // Map request codes to operations; unused codes become no-ops.
  always_comb begin
    unique case (in_req_type)
      hdbu_pkg::REQ_TICK:   op = hdbu_pkg::OP_TICK;
      hdbu_pkg::REQ_LOAD:   op = hdbu_pkg::OP_LOAD;
      hdbu_pkg::REQ_POP:    op = hdbu_pkg::OP_POP;
      hdbu_pkg::REQ_RX_ON:  op = hdbu_pkg::OP_RX_ON;
      hdbu_pkg::REQ_RX_OFF: op = hdbu_pkg::OP_RX_OFF;
      default:              op = hdbu_pkg::OP_NOP;
    endcase
    new_cmd = '{op: op, line_in: in_line_in, tx_byte: in_tx_byte, tx_last: in_tx_last};
  end

  assign in_ready  = (count_r != hdbu_pkg::QCNT_W'(hdbu_pkg::QUEUE_DEPTH));
  assign push      = in_valid && in_ready;
  assign cmd_valid = (count_r != '0);
  assign pop       = cmd_take && cmd_valid;
  assign cmd       = queue_r[rd_sel_r];

  // Pointer and count updates with wrap at the queue depth.
  always_comb begin
    wr_sel_nxt = wr_sel_r;
    rd_sel_nxt = rd_sel_r;
    if (push) begin
      wr_sel_nxt = (wr_sel_r == hdbu_pkg::QSEL_W'(hdbu_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : wr_sel_r + 1'b1;
    end
    if (pop) begin
      rd_sel_nxt = (rd_sel_r == hdbu_pkg::QSEL_W'(hdbu_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : rd_sel_r + 1'b1;
    end
    count_nxt = count_r + hdbu_pkg::QCNT_W'(push) - hdbu_pkg::QCNT_W'(pop);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_sel_r <= '0;
      rd_sel_r <= '0;
      count_r  <= '0;
    end else begin
      wr_sel_r <= wr_sel_nxt;
      rd_sel_r <= rd_sel_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_sel_r] <= new_cmd;
    end
  end

endmodule

// ===== rtl/core/hdbu_back.sv =====
// Back end: transmitter, receiver, receive FIFO memory and the result register.
// Depends on hdbu_pkg.
module hdbu_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  input  hdbu_pkg::cmd_t       cmd,
  output logic                 cmd_take,
  output logic                 res_valid,
  input  logic                 res_ready,
  output hdbu_pkg::status_t    res_status,
  output logic [7:0]           res_data
);

  logic [7:0]                  tx_shift_r, tx_shift_nxt;
  logic [3:0]                  tx_phase_r, tx_phase_nxt;
  logic                        tx_busy_r, tx_busy_nxt;
  logic                        tx_extra_r, tx_extra_nxt;
  logic [7:0]                  rx_shift_r, rx_shift_nxt;
  logic [3:0]                  rx_phase_r, rx_phase_nxt;
  logic                        rx_en_r, rx_en_nxt;
  logic [hdbu_pkg::PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [hdbu_pkg::PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic                        ovf_r, ovf_nxt;
  logic                        drive_r, drive_nxt;
  logic                        level_r, level_nxt;
  logic                        out_valid_r;
  hdbu_pkg::status_t           status_r, status_nxt;
  logic [7:0]                  rd_data_r;
  logic [7:0]                  mem [hdbu_pkg::FIFO_DEPTH];
  logic                        mem_we;
  logic                        pop_ok;
  logic                        exec;
  logic [hdbu_pkg::PTR_W-1:0]  wr_ptr_inc, rd_ptr_inc;
  logic [hdbu_pkg::CNT_W-1:0]  fill;

  // Execute whenever a command waits and the result register can take its result.
  assign exec     = cmd_valid && (!out_valid_r || res_ready);
  assign cmd_take = exec;

  assign wr_ptr_inc = (wr_ptr_r == hdbu_pkg::PTR_W'(hdbu_pkg::FIFO_DEPTH - 1)) ? '0
                                                                             : wr_ptr_r + 1'b1;
  assign rd_ptr_inc = (rd_ptr_r == hdbu_pkg::PTR_W'(hdbu_pkg::FIFO_DEPTH - 1)) ? '0
                                                                             : rd_ptr_r + 1'b1;

  // State update for one command.
  always_comb begin
    tx_shift_nxt = tx_shift_r;
    tx_phase_nxt = tx_phase_r;
    tx_busy_nxt  = tx_busy_r;
    tx_extra_nxt = tx_extra_r;
    rx_shift_nxt = rx_shift_r;
    rx_phase_nxt = rx_phase_r;
    rx_en_nxt    = rx_en_r;
    wr_ptr_nxt   = wr_ptr_r;
    rd_ptr_nxt   = rd_ptr_r;
    ovf_nxt      = ovf_r;
    drive_nxt    = drive_r;
    level_nxt    = level_r;
    mem_we       = 1'b0;
    pop_ok       = 1'b0;
    unique case (cmd.op)
      hdbu_pkg::OP_TICK: begin
        // Transmitter: start bit, eight data bits, stop bit, optional idle bit.
        if (tx_busy_r) begin
          if (tx_phase_r == hdbu_pkg::PH_START) begin
            level_nxt    = 1'b0;
            tx_phase_nxt = hdbu_pkg::PH_FIRST;
          end else if (tx_phase_r <= hdbu_pkg::PH_LAST_DATA) begin
            level_nxt    = tx_shift_r[0];
            tx_shift_nxt = {1'b0, tx_shift_r[7:1]};
            tx_phase_nxt = tx_phase_r + 4'd1;
          end else if (tx_phase_r == hdbu_pkg::PH_STOP && tx_extra_r) begin
            level_nxt    = 1'b1;
            tx_phase_nxt = hdbu_pkg::PH_EXTRA;
          end else begin
            level_nxt    = 1'b1;
            tx_phase_nxt = hdbu_pkg::PH_START;
            tx_busy_nxt  = 1'b0;
            tx_extra_nxt = 1'b0;
          end
        end
        // Receiver: wait for a low start bit, shift LSB first, check stop bit.
        if (rx_en_r) begin
          if (rx_phase_r == hdbu_pkg::PH_START) begin
            if (!cmd.line_in) begin
              rx_phase_nxt = hdbu_pkg::PH_FIRST;
              rx_shift_nxt = '0;
            end
          end else if (rx_phase_r <= hdbu_pkg::PH_LAST_DATA) begin
            rx_shift_nxt = {cmd.line_in, rx_shift_r[7:1]};
            rx_phase_nxt = rx_phase_r + 4'd1;
          end else begin
            if (cmd.line_in) begin
              if (wr_ptr_inc != rd_ptr_r) begin
                mem_we     = 1'b1;
                wr_ptr_nxt = wr_ptr_inc;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            rx_phase_nxt = hdbu_pkg::PH_START;
          end
        end
      end
      hdbu_pkg::OP_LOAD: begin
        if (!tx_busy_r) begin
          tx_shift_nxt = cmd.tx_byte;
          tx_phase_nxt = hdbu_pkg::PH_START;
          tx_busy_nxt  = 1'b1;
          tx_extra_nxt = cmd.tx_last;
          drive_nxt    = 1'b1;
        end
      end
      hdbu_pkg::OP_POP: begin
        if (wr_ptr_r != rd_ptr_r) begin
          pop_ok     = 1'b1;
          rd_ptr_nxt = rd_ptr_inc;
        end
      end
      hdbu_pkg::OP_RX_ON: begin
        rx_en_nxt    = 1'b1;
        rx_phase_nxt = hdbu_pkg::PH_START;
        drive_nxt    = 1'b0;
      end
      hdbu_pkg::OP_RX_OFF: begin
        rx_en_nxt    = 1'b0;
        rx_phase_nxt = hdbu_pkg::PH_START;
        drive_nxt    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Fill level after the update, write minus read modulo the depth.
  always_comb begin
    if (wr_ptr_nxt >= rd_ptr_nxt) begin
      fill = hdbu_pkg::CNT_W'(wr_ptr_nxt) - hdbu_pkg::CNT_W'(rd_ptr_nxt);
    end else begin
      fill = hdbu_pkg::CNT_W'(wr_ptr_nxt) + hdbu_pkg::CNT_W'(hdbu_pkg::FIFO_DEPTH)
             - hdbu_pkg::CNT_W'(rd_ptr_nxt);
    end
    status_nxt = '{line_out:      level_nxt,
                   drive_enable:  drive_nxt,
                   tx_active:     tx_busy_nxt,
                   rx_data_valid: pop_ok,
                   rx_fill:       hdbu_pkg::FILL_W'(fill),
                   rx_overflow:   ovf_nxt};
  end

  // Control state and engine registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_shift_r  <= '0;
      tx_phase_r  <= hdbu_pkg::PH_START;
      tx_busy_r   <= 1'b0;
      tx_extra_r  <= 1'b0;
      rx_shift_r  <= '0;
      rx_phase_r  <= hdbu_pkg::PH_START;
      rx_en_r     <= 1'b0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      ovf_r       <= 1'b0;
      drive_r     <= 1'b1;
      level_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (exec) begin
        tx_shift_r <= tx_shift_nxt;
        tx_phase_r <= tx_phase_nxt;
        tx_busy_r  <= tx_busy_nxt;
        tx_extra_r <= tx_extra_nxt;
        rx_shift_r <= rx_shift_nxt;
        rx_phase_r <= rx_phase_nxt;
        rx_en_r    <= rx_en_nxt;
        wr_ptr_r   <= wr_ptr_nxt;
        rd_ptr_r   <= rd_ptr_nxt;
        ovf_r      <= ovf_nxt;
        drive_r    <= drive_nxt;
        level_r    <= level_nxt;
      end
      if (exec) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload and FIFO memory; the read port is registered with the result.
  always_ff @(posedge clk) begin
    if (exec) begin
      status_r  <= status_nxt;
      rd_data_r <= mem[rd_ptr_r];
    end
    if (exec && mem_we) begin
      mem[wr_ptr_r] <= rx_shift_r;
    end
  end

  assign res_valid  = out_valid_r;
  assign res_status = status_r;
  assign res_data   = status_r.rx_data_valid ? rd_data_r : 8'd0;

endmodule

// ===== rtl/core/hdbu_checker.sv =====
// Port-level checks for the half-duplex serial engine, bound to the top level.
// Depends on half_duplex_bitbang_uart_assert.svh.
`include "half_duplex_bitbang_uart_assert.svh"

module hdbu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_rx_data,
  input logic       out_rx_data_valid,
  input logic [4:0] out_rx_fill,
  input logic       out_rx_overflow,
  input logic       out_tx_active
);

  logic seen_ovf_r;

  // Remember that an overflow was reported in a delivered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_ovf_r <= 1'b0;
    end else if (out_valid && out_ready && out_rx_overflow) begin
      seen_ovf_r <= 1'b1;
    end
  end

  // A result without a popped byte, as from an empty pop, returns a zero byte.
  `HDBU_ASSERT_SAME(a_empty_pop_zero, out_valid && !out_rx_data_valid, out_rx_data == 8'd0, "rx_data not zero without a popped byte")

  // Overflow stays set once reported.
  `HDBU_ASSERT_SAME(a_overflow_sticky, out_valid && seen_ovf_r, out_rx_overflow, "rx_overflow cleared after being reported")

  // A stalled result keeps its byte, fill level and transmit flag.
  `HDBU_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(out_rx_data) && $stable(out_rx_fill) && $stable(out_tx_active), "stalled result changed")

endmodule

bind half_duplex_bitbang_uart hdbu_checker u_hdbu_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_rx_data       (out_ch.rx_data),
  .out_rx_data_valid (out_ch.rx_data_valid),
  .out_rx_fill       (out_ch.rx_fill),
  .out_rx_overflow   (out_ch.rx_overflow),
  .out_tx_active     (out_ch.tx_active)
);

// ===== test/testbench.sv =====
// Self-checking testbench for the half-duplex single-wire serial engine.
// Uses hdbu_pkg and the hdbu_in_if / hdbu_out_if channels; drives requests, predicts results.
// A directed table runs first, then random receive frames, transmit bursts, pops and noise.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Request codes the block leaves unused.
  localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

  localparam int RANDOM_ITEMS   = 850;
  localparam int FRAMES_TO_FILL = 36;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct {
    logic [2:0] kind;
    logic       line;
    logic [7:0] data;
    logic       last;
  } uart_req_t;

  typedef struct {
    logic       line_out;
    logic       drive_en;
    logic       tx_active;
    logic [7:0] rx_data;
    logic       rx_valid;
    logic [4:0] fill;
    logic       overflow;
  } engine_status_t;

  typedef struct {
    uart_req_t      req;
    bit             typed;
    engine_status_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  hdbu_in_if  in_ch();
  hdbu_out_if out_ch();

  half_duplex_bitbang_uart u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #2 clk = ~clk;

  // Shadow copy of the engine state.
  logic [7:0]  tx_bits;
  logic [3:0]  tx_phase;
  logic        tx_busy;
  logic        tx_trailer;
  logic [7:0]  rx_bits;
  logic [3:0]  rx_phase;
  logic        rx_armed;
  logic [7:0]  rx_store [hdbu_pkg::FIFO_DEPTH];
  int unsigned wr_ptr;
  int unsigned rd_ptr;
  logic        overflow_seen;
  logic        driving;
  logic        wire_level;

  engine_status_t status_due_q[$];
  stim_row_t      stim_rows[$];
  int             mismatch_count = 0;
  int             send_idle_pct  = 0;
  int             recv_idle_pct  = 0;
  int             quiet_cycles   = 0;
  bit             gen_rx_armed   = 1'b0;

  task automatic reset_engine_model();
    tx_bits       = '0;
    tx_phase      = hdbu_pkg::PH_START;
    tx_busy       = 1'b0;
    tx_trailer    = 1'b0;
    rx_bits       = '0;
    rx_phase      = hdbu_pkg::PH_START;
    rx_armed      = 1'b0;
    wr_ptr        = 0;
    rd_ptr        = 0;
    overflow_seen = 1'b0;
    driving       = 1'b1;
    wire_level    = 1'b1;
  endtask

  function automatic int unsigned fifo_fill();
    return (wr_ptr + hdbu_pkg::FIFO_DEPTH - rd_ptr) % hdbu_pkg::FIFO_DEPTH;
  endfunction

  // Applies one request to the shadow state and returns the status it reports.
  function automatic engine_status_t advance_engine(uart_req_t r);
    engine_status_t s;
    int unsigned    next_wr;
    s.rx_data  = 8'h00;
    s.rx_valid = 1'b0;
    unique case (r.kind)
      hdbu_pkg::REQ_TICK: begin
        // Transmitter moves first, then the receiver samples the wire.
        if (tx_busy) begin
          if (tx_phase == hdbu_pkg::PH_START) begin
            wire_level = 1'b0;
            tx_phase   = hdbu_pkg::PH_FIRST;
          end else if (tx_phase <= hdbu_pkg::PH_LAST_DATA) begin
            wire_level = tx_bits[0];
            tx_bits    = tx_bits >> 1;
            tx_phase   = tx_phase + 4'd1;
          end else if (tx_phase == hdbu_pkg::PH_STOP && tx_trailer) begin
            wire_level = 1'b1;
            tx_phase   = hdbu_pkg::PH_EXTRA;
          end else begin
            wire_level = 1'b1;
            tx_phase   = hdbu_pkg::PH_START;
            tx_busy    = 1'b0;
            tx_trailer = 1'b0;
          end
        end
        if (rx_armed) begin
          if (rx_phase == hdbu_pkg::PH_START) begin
            if (!r.line) begin
              rx_phase = hdbu_pkg::PH_FIRST;
              rx_bits  = 8'h00;
            end
          end else if (rx_phase <= hdbu_pkg::PH_LAST_DATA) begin
            rx_bits  = {r.line, rx_bits[7:1]};
            rx_phase = rx_phase + 4'd1;
          end else begin
            // A low stop bit drops the byte silently.
            if (r.line) begin
              next_wr = (wr_ptr + 1) % hdbu_pkg::FIFO_DEPTH;
              if (next_wr != rd_ptr) begin
                rx_store[wr_ptr] = rx_bits;
                wr_ptr           = next_wr;
              end else begin
                overflow_seen = 1'b1;
              end
            end
            rx_phase = hdbu_pkg::PH_START;
          end
        end
      end
      hdbu_pkg::REQ_LOAD: begin
        if (!tx_busy) begin
          tx_bits    = r.data;
          tx_phase   = hdbu_pkg::PH_START;
          tx_busy    = 1'b1;
          tx_trailer = r.last;
          driving    = 1'b1;
        end
      end
      hdbu_pkg::REQ_POP: begin
        if (fifo_fill() != 0) begin
          s.rx_data  = rx_store[rd_ptr];
          s.rx_valid = 1'b1;
          rd_ptr     = (rd_ptr + 1) % hdbu_pkg::FIFO_DEPTH;
        end
      end
      hdbu_pkg::REQ_RX_ON: begin
        rx_armed = 1'b1;
        rx_phase = hdbu_pkg::PH_START;
        driving  = 1'b0;
      end
      hdbu_pkg::REQ_RX_OFF: begin
        rx_armed = 1'b0;
        rx_phase = hdbu_pkg::PH_START;
        driving  = 1'b1;
      end
      default: begin
      end
    endcase
    s.line_out  = wire_level;
    s.drive_en  = driving;
    s.tx_active = tx_busy;
    s.fill      = 5'(fifo_fill());
    s.overflow  = overflow_seen;
    return s;
  endfunction

  function automatic engine_status_t status_of(logic line_out, logic drive_en, logic tx_active,
                                               logic [7:0] rx_data, logic rx_valid,
                                               logic [4:0] fill, logic overflow);
    engine_status_t s;
    s.line_out  = line_out;
    s.drive_en  = drive_en;
    s.tx_active = tx_active;
    s.rx_data   = rx_data;
    s.rx_valid  = rx_valid;
    s.fill      = fill;
    s.overflow  = overflow;
    return s;
  endfunction

  function automatic void add_row(logic [2:0] kind, logic line, logic [7:0] data, logic last);
    stim_row_t row;
    row.req.kind = kind;
    row.req.line = line;
    row.req.data = data;
    row.req.last = last;
    row.typed    = 1'b0;
    row.want     = status_of(1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0, 1'b0);
    stim_rows.push_back(row);
  endfunction

  function automatic void add_typed(logic [2:0] kind, logic line, logic [7:0] data, logic last,
                                    engine_status_t want);
    add_row(kind, line, data, last);
    stim_rows[stim_rows.size() - 1].typed = 1'b1;
    stim_rows[stim_rows.size() - 1].want  = want;
  endfunction

  // Directed table: idle checks, ignored requests, then one frame out and one frame in at once.
  task automatic build_directed();
    engine_status_t idle_drv;
    engine_status_t idle_rel;
    logic [7:0]     rx_pattern;
    idle_drv   = status_of(1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 5'd0, 1'b0);
    idle_rel   = status_of(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0, 1'b0);
    rx_pattern = 8'h81;
    add_typed(hdbu_pkg::REQ_TICK,   1'b1, 8'h00, 1'b0, idle_drv);
    add_typed(hdbu_pkg::REQ_POP,    1'b0, 8'h00, 1'b0, idle_drv);
    add_typed(REQ_SPARE_FIRST,      1'b1, 8'hFF, 1'b1, idle_drv);
    add_typed(REQ_SPARE_LAST,       1'b0, 8'h00, 1'b0, idle_drv);
    add_typed(hdbu_pkg::REQ_RX_OFF, 1'b0, 8'h00, 1'b0, idle_drv);
    add_typed(hdbu_pkg::REQ_LOAD,   1'b0, 8'h00, 1'b1,
              status_of(1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 5'd0, 1'b0));
    // Load while busy must be ignored.
    add_typed(hdbu_pkg::REQ_LOAD,   1'b1, 8'hFF, 1'b0,
              status_of(1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 5'd0, 1'b0));
    add_typed(hdbu_pkg::REQ_RX_ON,  1'b0, 8'h00, 1'b0,
              status_of(1'b1, 1'b0, 1'b1, 8'h00, 1'b0, 5'd0, 1'b0));
    add_row(hdbu_pkg::REQ_TICK, 1'b0, 8'h00, 1'b0);
    for (int i = 0; i < 8; i++) add_row(hdbu_pkg::REQ_TICK, rx_pattern[i], 8'h00, 1'b0);
    add_row(hdbu_pkg::REQ_TICK, 1'b1, 8'h00, 1'b0);
    add_row(hdbu_pkg::REQ_TICK, 1'b1, 8'h00, 1'b0);
    add_row(hdbu_pkg::REQ_POP, 1'b0, 8'h00, 1'b0);
    add_typed(hdbu_pkg::REQ_POP,    1'b1, 8'h00, 1'b0, idle_rel);
    add_typed(hdbu_pkg::REQ_RX_OFF, 1'b1, 8'h00, 1'b0, idle_drv);
  endtask

  function automatic void add_random_tick(logic line);
    add_row(hdbu_pkg::REQ_TICK, line, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endfunction

  // One receive frame: optional arm and load, idle bits, start, eight data bits, stop.
  function automatic void gen_rx_frame(bit clean_stop);
    logic [7:0] payload;
    payload = 8'($urandom_range(0, 255));
    if (!gen_rx_armed || $urandom_range(0, 6) == 0) begin
      add_row(hdbu_pkg::REQ_RX_ON, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
              1'b0);
      gen_rx_armed = 1'b1;
    end
    if ($urandom_range(0, 2) == 0)
      add_row(hdbu_pkg::REQ_LOAD, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)));
    repeat ($urandom_range(0, 2)) add_random_tick(1'b1);
    add_random_tick(1'b0);
    for (int i = 0; i < 8; i++) add_random_tick(payload[i]);
    add_random_tick(clean_stop);
  endfunction

  function automatic void gen_tx_burst();
    add_row(hdbu_pkg::REQ_LOAD, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
            1'($urandom_range(0, 1)));
    repeat ($urandom_range(9, 12)) add_random_tick(1'($urandom_range(0, 1)));
  endfunction

  function automatic void gen_noise(bit allow_pop);
    logic [2:0] kind;
    repeat ($urandom_range(1, 3)) begin
      kind = 3'($urandom_range(0, 7));
      if (!allow_pop && kind == hdbu_pkg::REQ_POP) kind = hdbu_pkg::REQ_TICK;
      if (kind == hdbu_pkg::REQ_RX_ON) gen_rx_armed = 1'b1;
      if (kind == hdbu_pkg::REQ_RX_OFF) gen_rx_armed = 1'b0;
      add_row(kind, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)));
    end
  endfunction

  // Random part: first fill the FIFO past full without pops, then a mix that drains it.
  task automatic build_random();
    int first_row;
    int clean_frames;
    int pick;
    bit clean;
    first_row    = stim_rows.size();
    clean_frames = 0;
    while (clean_frames < FRAMES_TO_FILL) begin
      pick = $urandom_range(0, 99);
      if (pick < 88) begin
        clean = ($urandom_range(0, 19) != 0);
        gen_rx_frame(clean);
        if (clean) clean_frames++;
      end else if (pick < 94) begin
        gen_tx_burst();
      end else begin
        gen_noise(1'b0);
      end
    end
    while (stim_rows.size() - first_row < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        gen_rx_frame($urandom_range(0, 99) < 85);
      end else if (pick < 60) begin
        repeat ($urandom_range(1, 6)) add_row(hdbu_pkg::REQ_POP, 1'($urandom_range(0, 1)),
                                             8'($urandom_range(0, 255)),
                                             1'($urandom_range(0, 1)));
      end else if (pick < 75) begin
        gen_tx_burst();
      end else if (pick < 83) begin
        add_row(hdbu_pkg::REQ_RX_OFF, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                1'b0);
        gen_rx_armed = 1'b0;
      end else begin
        gen_noise(1'b1);
      end
    end
  endtask

  task automatic report_mismatch(string field, int got, int want);
    mismatch_count++;
    $display("mismatch at %0t ns: %s got 0x%0h, expected 0x%0h", $realtime, field, got, want);
  endtask

  // Drives one request from a falling edge and waits for it to be taken.
  task automatic send_request(stim_row_t row);
    engine_status_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= row.req.kind;
    in_ch.line_in  <= row.req.line;
    in_ch.tx_byte  <= row.req.data;
    in_ch.tx_last  <= row.req.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    want = advance_engine(row.req);
    if (row.typed) want = row.want;
    status_due_q.push_back(want);
    @(negedge clk);
  endtask

  // Result side: random stalls, changed on the falling edge.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    engine_status_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (status_due_q.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = status_due_q.pop_front();
        if (out_ch.line_out !== want.line_out)
          report_mismatch("line_out", out_ch.line_out, want.line_out);
        if (out_ch.drive_enable !== want.drive_en)
          report_mismatch("drive_enable", out_ch.drive_enable, want.drive_en);
        if (out_ch.tx_active !== want.tx_active)
          report_mismatch("tx_active", out_ch.tx_active, want.tx_active);
        if (out_ch.rx_data !== want.rx_data)
          report_mismatch("rx_data", out_ch.rx_data, want.rx_data);
        if (out_ch.rx_data_valid !== want.rx_valid)
          report_mismatch("rx_data_valid", out_ch.rx_data_valid, want.rx_valid);
        if (out_ch.rx_fill !== want.fill)
          report_mismatch("rx_fill", out_ch.rx_fill, want.fill);
        if (out_ch.rx_overflow !== want.overflow)
          report_mismatch("rx_overflow", out_ch.rx_overflow, want.overflow);
      end
    end
  end

  // Watchdog: too long without any request or result moving ends the run.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", status_due_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence: reset, stimulus in three idling phases, drain, verdict.
  initial begin
    int mode;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.req_type = hdbu_pkg::REQ_TICK;
    in_ch.line_in  = 1'b1;
    in_ch.tx_byte  = 8'h00;
    in_ch.tx_last  = 1'b0;
    reset_engine_model();
    build_directed();
    build_random();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (stim_rows[i]) begin
      mode = (i * 3) / stim_rows.size();
      unique case (mode)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 55;
        end
        1: begin
          send_idle_pct = 55;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      send_request(stim_rows[i]);
    end
    in_ch.valid <= 1'b0;
    while (status_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/hdbu_pkg.sv
rtl/core/hdbu_if.sv
rtl/core/hdbu_front.sv
rtl/core/hdbu_back.sv
rtl/core/half_duplex_bitbang_uart.sv
rtl/core/hdbu_checker.sv
test/testbench.sv
